@@ hdl/assert_macros.svh @@
// Assertion helpers; every property is clocked on i_clk and muted during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define RAT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rat_pkg.sv @@
package rat_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int TARGET_BITS = 10;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int TGT_W       = TARGET_BITS + 1;
    localparam int USES_W      = 16;

    // Port field widths
    localparam int KIND_W   = 1;
    localparam int TNUM_W   = 10;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int KEEP_W   = (TARGET_BITS < TNUM_W) ? TARGET_BITS : TNUM_W;

    // All-ones code marks an unused surface or bone field
    localparam logic [TGT_W-1:0]  NO_TARGET = '1;
    localparam logic [USES_W-1:0] USES_MAX  = '1;
    localparam logic [USES_W-1:0] USES_ONE  = USES_W'(1);

    typedef struct packed {
        logic [TGT_W-1:0]  surface;
        logic [TGT_W-1:0]  bone;
        logic [USES_W-1:0] uses;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_REUSE = 2'd1,
        ST_NEW   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Sequencer step addresses
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_NEXT,
        S_HIT,
        S_DECIDE
    } t_step;

    // Branch conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_HIT,
        C_LAST,
        C_OUT_FREE
    } t_cond;

    // Datapath operations
    typedef enum logic [2:0] {
        A_LATCH,
        A_READ,
        A_NOTE,
        A_NEXT,
        A_HIT,
        A_NEW
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_step tgt_true;
        t_step tgt_false;
        t_act  act;
    } t_uword;

    // Control store: one word per step
    function automatic t_uword rat_ucode(input t_step step);
        t_uword uw;
        unique case (step)
            S_IDLE:   uw = '{cond: C_IN_VALID, tgt_true: S_READ,   tgt_false: S_IDLE,
                             act: A_LATCH};
            S_READ:   uw = '{cond: C_ALWAYS,   tgt_true: S_CHECK,  tgt_false: S_CHECK,
                             act: A_READ};
            S_CHECK:  uw = '{cond: C_HIT,      tgt_true: S_HIT,    tgt_false: S_NEXT,
                             act: A_NOTE};
            S_NEXT:   uw = '{cond: C_LAST,     tgt_true: S_DECIDE, tgt_false: S_CHECK,
                             act: A_NEXT};
            S_HIT:    uw = '{cond: C_OUT_FREE, tgt_true: S_IDLE,   tgt_false: S_HIT,
                             act: A_HIT};
            S_DECIDE: uw = '{cond: C_OUT_FREE, tgt_true: S_IDLE,   tgt_false: S_DECIDE,
                             act: A_NEW};
            default:  uw = '{cond: C_ALWAYS,   tgt_true: S_IDLE,   tgt_false: S_IDLE,
                             act: A_READ};
        endcase
        return uw;
    endfunction

endpackage

@@ hdl/refcounted_attach_table_top.sv @@
// A hit ends the scan at its slot; a reuse, a new allocation or a full report
// follows the scan of every slot. Requests: one at a time, set by the scan of
// the single entry RAM read port (two sequencer steps per slot); a new request
// is taken only while the sequencer is idle. Reset: synchronous, active low;
// clears the sequencer, the allocated bits and count, the scan flags and the
// output valid. Entry RAM contents stay undefined until written.
`include "assert_macros.svh"

module refcounted_attach_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rat_pkg::KIND_W-1:0]    i_target_kind,
    input  logic [rat_pkg::TNUM_W-1:0]    i_target_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rat_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [rat_pkg::STATUS_W-1:0]  o_status,
    output logic [rat_pkg::USES_W-1:0]    o_use_count
);

    import rat_pkg::*;

    // Sequencer
    t_step  r_upc, n_upc;
    t_uword w_uw;
    logic   w_fire;

    // Request and scan registers
    logic             r_is_bone;
    logic [TGT_W-1:0] r_tgt;
    logic [IDX_W-1:0] r_idx;
    logic             r_empty_ok;
    logic [IDX_W-1:0] r_empty;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free;
    t_entry           r_entry;

    // Table control state
    logic [MAX_ENTRIES-1:0] r_alloc;
    logic [CNT_W-1:0]       r_alloc_cnt;

    // Output beat
    logic              r_o_valid;
    logic [SLOT_W-1:0] r_o_slot;
    t_status           r_o_status;
    logic [USES_W-1:0] r_o_uses;

    // Datapath signals
    t_entry            w_rd;
    t_entry            w_new_entry;
    t_entry            w_wdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_idx_inc;
    logic [TGT_W-1:0]  w_held;
    logic [TGT_W-1:0]  w_in_tgt;
    logic [USES_W-1:0] w_uses_inc;
    logic              w_hit;
    logic              w_empty;
    logic              w_last;
    logic              w_out_free;
    logic              w_in_acc;
    logic              w_do_hit;
    logic              w_do_new;
    logic              w_set_alloc;
    t_status           w_status;
    logic [SLOT_W-1:0] w_slot;
    logic [USES_W-1:0] w_uses;

    // Entry store
    rat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Compare and scan helpers
    assign w_in_tgt   = TGT_W'(i_target_number[KEEP_W-1:0]);
    assign w_idx_inc  = r_idx + 1'b1;
    assign w_last     = (r_idx == IDX_W'(MAX_ENTRIES - 1));
    assign w_held     = r_is_bone ? w_rd.bone : w_rd.surface;
    assign w_hit      = r_alloc[r_idx] && (w_held == r_tgt);
    assign w_empty    = r_alloc[r_idx] && (w_rd.bone == NO_TARGET)
                        && (w_rd.surface == NO_TARGET);
    assign w_out_free = !r_o_valid || i_ready;
    assign w_uses_inc = (r_entry.uses == USES_MAX) ? USES_MAX : r_entry.uses + 1'b1;

    assign w_new_entry.surface = r_is_bone ? NO_TARGET : r_tgt;
    assign w_new_entry.bone    = r_is_bone ? r_tgt : NO_TARGET;
    assign w_new_entry.uses    = USES_ONE;

    // Decode the control word and branch
    always_comb begin
        w_uw = rat_ucode(r_upc);
        unique case (w_uw.cond)
            C_ALWAYS:   w_fire = 1'b1;
            C_IN_VALID: w_fire = i_valid;
            C_HIT:      w_fire = w_hit;
            C_LAST:     w_fire = w_last;
            C_OUT_FREE: w_fire = w_out_free;
            default:    w_fire = 1'b0;
        endcase
        n_upc = w_fire ? w_uw.tgt_true : w_uw.tgt_false;
    end

    // Step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign w_in_acc = (w_uw.act == A_LATCH) && w_fire;
    assign w_do_hit = (w_uw.act == A_HIT) && w_fire;
    assign w_do_new = (w_uw.act == A_NEW) && w_fire;

    // Read address: advance one slot on the next step
    assign w_raddr = (w_uw.act == A_NEXT) ? w_idx_inc : r_idx;

    // Commit: pick slot, status and write data
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_new_entry;
        w_set_alloc = 1'b0;
        w_status    = ST_FULL;
        w_slot      = '0;
        w_uses      = '0;
        if (w_do_hit) begin
            w_we          = 1'b1;
            w_wdata       = r_entry;
            w_wdata.uses  = w_uses_inc;
            w_status      = ST_HIT;
            w_slot        = SLOT_W'(r_idx);
            w_uses        = w_uses_inc;
        end else if (w_do_new) begin
            if (r_empty_ok) begin
                w_we     = 1'b1;
                w_waddr  = r_empty;
                w_status = ST_REUSE;
                w_slot   = SLOT_W'(r_empty);
                w_uses   = USES_ONE;
            end else if (r_free_ok) begin
                w_we        = 1'b1;
                w_waddr     = r_free;
                w_set_alloc = 1'b1;
                w_status    = ST_NEW;
                w_slot      = SLOT_W'(r_free);
                w_uses      = USES_ONE;
            end
        end
    end

    // Control state: allocated bits, count, output valid, scan flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc     <= '0;
            r_alloc_cnt <= '0;
            r_o_valid   <= 1'b0;
            r_empty_ok  <= 1'b0;
            r_free_ok   <= 1'b0;
        end else begin
            if (w_set_alloc) begin
                r_alloc[r_free] <= 1'b1;
                r_alloc_cnt     <= r_alloc_cnt + 1'b1;
            end
            if (w_do_hit || w_do_new) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_empty_ok <= 1'b0;
                r_free_ok  <= 1'b0;
            end else if (w_uw.act == A_NOTE) begin
                if (w_empty && !r_empty_ok) begin
                    r_empty_ok <= 1'b1;
                end
                if (!r_alloc[r_idx] && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
        end
    end

    // Payload: request, scan position, candidate slots, output beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_is_bone <= i_target_kind[0];
            r_tgt     <= w_in_tgt;
            r_idx     <= '0;
        end else if (w_uw.act == A_NEXT) begin
            r_idx <= w_idx_inc;
        end
        if (w_uw.act == A_NOTE) begin
            r_entry <= w_rd;
            if (w_empty && !r_empty_ok) begin
                r_empty <= r_idx;
            end
            if (!r_alloc[r_idx] && !r_free_ok) begin
                r_free <= r_idx;
            end
        end
        if (w_do_hit || w_do_new) begin
            r_o_slot   <= w_slot;
            r_o_status <= w_status;
            r_o_uses   <= w_uses;
        end
    end

    assign o_ready      = (r_upc == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_slot_index = r_o_slot;
    assign o_status     = r_o_status;
    assign o_use_count  = r_o_uses;

    // Checks
    `RAT_ASSERT_ALWAYS(a_alloc_count, r_alloc_cnt == $countones(r_alloc), "allocated count drifted")
    `RAT_ASSERT_IMPL(a_full_only_when_full, w_do_new && (w_status == ST_FULL), &r_alloc, "full reported with a free slot")
    `RAT_ASSERT_IMPL(a_hit_allocated, w_do_hit, r_alloc[r_idx], "hit on an unallocated slot")
    `RAT_ASSERT_IMPL(a_new_slot_free, w_set_alloc, !r_alloc[r_free], "allocating a slot already in use")
    `RAT_ASSERT_NEXT(a_beat_loaded, w_do_hit || w_do_new, o_valid, "committed result not presented")

endmodule

@@ hdl/rat_ram.sv @@
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import rat_pkg::*;

    localparam int POOL_SIZE    = 96;
    localparam int RANDOM_ITEMS = 1280;
    localparam int BURST_HITS   = 300;
    localparam int IDLE_PCT     = 19;
    localparam int SCAN_CYCLES  = 2 * MAX_ENTRIES + 3;
    localparam int STUCK_LIMIT  = 16 * SCAN_CYCLES;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TNUM_W-1:0] number;
    } t_attach_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic [USES_W-1:0] uses;
    } t_attach_rsp;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_ready;
    logic [KIND_W-1:0]   req_kind   = '0;
    logic [TNUM_W-1:0]   req_number = '0;
    logic                rsp_valid;
    logic                rsp_ready  = 1'b0;
    logic [SLOT_W-1:0]   rsp_slot;
    logic [STATUS_W-1:0] rsp_status;
    logic [USES_W-1:0]   rsp_uses;

    // Shadow copy of the attachment table
    bit                  tbl_alloc   [MAX_ENTRIES];
    bit [TGT_W-1:0]      tbl_surface [MAX_ENTRIES];
    bit [TGT_W-1:0]      tbl_bone    [MAX_ENTRIES];
    bit [USES_W-1:0]     tbl_uses    [MAX_ENTRIES];
    int                  tbl_count;

    t_attach_req         req_pending  [$];
    t_attach_rsp         rsp_expected [$];
    bit                  req_taken    = 1'b0;
    bit                  stall_enable = 1'b1;
    int                  err_count    = 0;
    int                  reqs_accepted = 0;
    int                  stuck_cycles = 0;
    int                  status_seen  [2**STATUS_W];
    int                  peak_uses    = 0;

    refcounted_attach_table_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (req_valid),
        .o_ready         (req_ready),
        .i_target_kind   (req_kind),
        .i_target_number (req_number),
        .o_valid         (rsp_valid),
        .i_ready         (rsp_ready),
        .o_slot_index    (rsp_slot),
        .o_status        (rsp_status),
        .o_use_count     (rsp_uses)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the slot report it yields
    function automatic t_attach_rsp attach_predict(input t_attach_req req);
        t_attach_rsp      rsp;
        logic [TGT_W-1:0] tgt;
        logic [TGT_W-1:0] held;
        bit               found;
        tgt   = TGT_W'(req.number[KEEP_W-1:0]);
        rsp   = '{slot: '0, status: ST_FULL, uses: '0};
        found = 1'b0;
        // Existing entry holding the target
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            held = req.kind[0] ? tbl_bone[i] : tbl_surface[i];
            if (!found && tbl_alloc[i] && held == tgt) begin
                if (tbl_uses[i] != USES_MAX)
                    tbl_uses[i] = tbl_uses[i] + 1'b1;
                rsp   = '{slot: SLOT_W'(i), status: ST_HIT, uses: tbl_uses[i]};
                found = 1'b1;
            end
        end
        // Allocated entry that holds nothing
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!found && tbl_alloc[i] && tbl_surface[i] == NO_TARGET &&
                tbl_bone[i] == NO_TARGET) begin
                if (req.kind[0])
                    tbl_bone[i] = tgt;
                else
                    tbl_surface[i] = tgt;
                tbl_uses[i] = USES_ONE;
                rsp   = '{slot: SLOT_W'(i), status: ST_REUSE, uses: USES_ONE};
                found = 1'b1;
            end
        end
        // Lowest free slot
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!found && !tbl_alloc[i]) begin
                tbl_alloc[i]   = 1'b1;
                tbl_surface[i] = req.kind[0] ? NO_TARGET : tgt;
                tbl_bone[i]    = req.kind[0] ? tgt : NO_TARGET;
                tbl_uses[i]    = USES_ONE;
                tbl_count      = tbl_count + 1;
                rsp   = '{slot: SLOT_W'(i), status: ST_NEW, uses: USES_ONE};
                found = 1'b1;
            end
        end
        return rsp;
    endfunction

    task automatic push_req(input logic [KIND_W-1:0] kind, input logic [TNUM_W-1:0] number);
        req_pending.push_back('{kind: kind, number: number});
    endtask

    // Hold until every queued request has been answered
    task automatic wait_drained();
        while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: advance to the next pending beat once the current one is taken
    always @(negedge i_clk) begin : drive_req
        t_attach_req nxt;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_taken) begin
            if (req_pending.size() != 0 &&
                !(stall_enable && $urandom_range(99) < IDLE_PCT)) begin
                nxt = req_pending.pop_front();
                req_valid  <= 1'b1;
                req_kind   <= nxt.kind;
                req_number <= nxt.number;
            end else begin
                req_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Result sink: stall at random while idling is enabled
    always @(negedge i_clk) begin
        if (!i_rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !stall_enable || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on each request beat, check each result beat
    always @(posedge i_clk) begin : monitor
        t_attach_rsp exp_rsp;
        if (i_rst_n) begin
            if (req_valid && req_ready) begin
                rsp_expected.push_back(attach_predict('{kind: req_kind, number: req_number}));
                req_taken = 1'b1;
                reqs_accepted++;
            end
            if (rsp_valid && rsp_ready) begin
                if (rsp_expected.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: slot %0d status %0d uses %0d",
                                 $realtime, rsp_slot, rsp_status, rsp_uses);
                end else begin
                    exp_rsp = rsp_expected.pop_front();
                    if (rsp_slot !== exp_rsp.slot || rsp_status !== exp_rsp.status ||
                        rsp_uses !== exp_rsp.uses) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"[%0t] mismatch: expected slot %0d status %0d uses %0d,",
                                      " got slot %0d status %0d uses %0d"}, $realtime,
                                     exp_rsp.slot, exp_rsp.status, exp_rsp.uses,
                                     rsp_slot, rsp_status, rsp_uses);
                    end
                    status_seen[exp_rsp.status]++;
                    if (int'(exp_rsp.uses) > peak_uses)
                        peak_uses = int'(exp_rsp.uses);
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding and no beat moving
    always @(posedge i_clk) begin
        if (i_rst_n && (req_valid || req_pending.size() != 0 || rsp_expected.size() != 0) &&
            !(req_valid && req_ready) && !(rsp_valid && rsp_ready))
            stuck_cycles++;
        else
            stuck_cycles = 0;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $realtime, stuck_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        t_attach_req pool [POOL_SIZE];
        int          pick;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, hits, surface and bone kept apart
        stall_enable = 1'b1;
        push_req(1'b0, 10'h000);
        push_req(1'b0, 10'h000);
        push_req(1'b1, 10'h000);
        push_req(1'b0, 10'h3FF);
        push_req(1'b1, 10'h3FF);
        push_req(1'b1, 10'h3FF);
        push_req(1'b0, 10'h2AA);
        push_req(1'b1, 10'h155);
        push_req(1'b0, 10'h155);
        push_req(1'b1, 10'h2AA);
        push_req(1'b1, 10'h155);
        push_req(1'b0, 10'h2AA);
        push_req(1'b1, 10'h000);
        push_req(1'b0, 10'h3FF);
        push_req(1'b1, 10'h200);
        push_req(1'b0, 10'h001);
        push_req(1'b0, 10'h200);
        push_req(1'b1, 10'h001);
        push_req(1'b0, 10'h000);
        wait_drained();

        // Hammer slot 0 back to back with no idling on either side
        stall_enable = 1'b0;
        repeat (BURST_HITS) push_req(1'b0, 10'h000);
        wait_drained();

        // Random: mostly repeats from a target pool, so the table fills and hits recur
        stall_enable = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = '{kind: KIND_W'($urandom_range(1)), number: TNUM_W'($urandom_range(1023))};
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 60)
                req_pending.push_back(pool[$urandom_range(POOL_SIZE - 1)]);
            else if (pick < 90)
                push_req(KIND_W'($urandom_range(1)), TNUM_W'($urandom_range(1023)));
            else
                push_req(KIND_W'($urandom_range(1)), $urandom_range(1) ? 10'h3FF : 10'h000);
        end
        wait_drained();
        repeat (SCAN_CYCLES + 8) @(posedge i_clk);

        if (rsp_expected.size() != 0) begin
            err_count += rsp_expected.size();
            $display("%0d expected results never arrived", rsp_expected.size());
        end
        $display("Ran %0d requests: %0d hits, %0d reuses, %0d new slots, %0d full reports",
                 reqs_accepted, status_seen[ST_HIT], status_seen[ST_REUSE],
                 status_seen[ST_NEW], status_seen[ST_FULL]);
        $display("Slots allocated %0d of %0d, highest use count %0d, errors %0d",
                 tbl_count, MAX_ENTRIES, peak_uses, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
